/* rtl/core/positional_array_list_engine_defines.svh */
// Assertion macros for the positional array list engine RTL, used by pale_ctrl.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define PALE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define PALE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PALE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PALE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/pale_pkg.sv */
// Shared types, codes and constants of the positional array list engine.
`timescale 1ns / 1ps

package pale_pkg;

   localparam int CAPACITY_DEF = 128;
   localparam int GROUP_SIZE   = 16;

   localparam int MODE_W    = 3;
   localparam int POS_W     = 8;
   localparam int VAL_W     = 32;
   localparam int ST_W      = 2;
   localparam int CNT_OUT_W = 8;

   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] data;
      logic [CNT_OUT_W-1:0]    count;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                    shift_up;
      logic                    shift_down;
      logic                    write_value;
      logic                    read;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FOLD,
      S_DRAIN
   } state_type;

endpackage

/* rtl/core/pale_req_if.sv */
// Valid/ready channel that carries request transactions.
`timescale 1ns / 1ps

interface pale_req_if import pale_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/pale_rsp_if.sv */
// Valid/ready channel that carries response transactions.
`timescale 1ns / 1ps

interface pale_rsp_if import pale_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/pale_cell.sv */
// One list entry of the cell row, with its shift, write and read-back logic.
`timescale 1ns / 1ps

module pale_cell import pale_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  cmd_type                 cmd,
   input  logic signed [VAL_W-1:0] left_value,
   input  logic signed [VAL_W-1:0] right_value,
   output logic signed [VAL_W-1:0] entry,
   output logic signed [VAL_W-1:0] read_value
);

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic signed [VAL_W-1:0] rd_ff;
   logic signed [VAL_W-1:0] rd_in;
   logic                    at_pos;
   logic                    above_pos;

   assign at_pos    = (int'(cmd.position) == INDEX);
   assign above_pos = (int'(cmd.position) < INDEX);

   always_comb begin
      priority if (cmd.shift_up && above_pos) begin
         entry_in = left_value;
      end else if (cmd.write_value && at_pos) begin
         entry_in = cmd.value;
      end else if (cmd.shift_down && (at_pos || above_pos)) begin
         entry_in = right_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Only the addressed cell drives its entry; all others give zero to the fold.
   assign rd_in = (cmd.read && at_pos) ? entry_ff : '0;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rd_ff    <= rd_in;
   end

   assign entry      = entry_ff;
   assign read_value = rd_ff;

endmodule

/* rtl/core/pale_ctrl.sv */
// Request decode, fill count, sequencing and response register of the list engine.
`timescale 1ns / 1ps
`include "positional_array_list_engine_defines.svh"

module pale_ctrl import pale_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp,
   output cmd_type                 cmd,
   output logic                    fold_en,
   input  logic signed [VAL_W-1:0] fold_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_c;
   logic [ST_W-1:0]  stat_ff;
   logic [ST_W-1:0]  stat_in;
   logic [ST_W-1:0]  status_c;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   cmd_type          cmd_c;
   logic             accept;
   logic             rsp_load;
   logic             list_empty;
   logic             list_full;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;

   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign pos_ext    = CMP_W'(req.position);
   assign cnt_ext    = CMP_W'(count_ff);

   // Decode of the request against the current fill count.
   always_comb begin
      status_c          = ST_OK;
      count_c           = count_ff;
      cmd_c             = '0;
      cmd_c.position    = req.position;
      cmd_c.value       = req.value;
      unique case (req.mode)
         MODE_CLEAR: begin
            count_c = '0;
         end
         MODE_READ: begin
            if (list_empty) begin
               status_c = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_c = ST_RANGE;
            end else begin
               cmd_c.read = 1'b1;
            end
         end
         MODE_INSERT: begin
            if (list_full) begin
               status_c = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_c = ST_RANGE;
            end else begin
               cmd_c.shift_up    = 1'b1;
               cmd_c.write_value = 1'b1;
               count_c           = count_ff + CNT_W'(1);
            end
         end
         MODE_OVERWRITE: begin
            if (list_empty) begin
               status_c = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_c = ST_RANGE;
            end else begin
               cmd_c.write_value = 1'b1;
            end
         end
         MODE_DELETE: begin
            if (list_empty) begin
               status_c = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_c = ST_RANGE;
            end else begin
               cmd_c.shift_down = 1'b1;
               count_c          = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer: accept, fold the read-back groups, then hand over the response.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      fold_en   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            fold_en  = 1'b1;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      cmd = cmd_c;
      if (!accept) begin
         cmd.shift_up    = 1'b0;
         cmd.shift_down  = 1'b0;
         cmd.write_value = 1'b0;
         cmd.read        = 1'b0;
      end
   end

   assign count_in = accept ? count_c : count_ff;
   assign stat_in  = accept ? status_c : stat_ff;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.status = stat_ff;
         rsp_in.data   = fold_data;
         rsp_in.count  = CNT_OUT_W'(count_ff);
         rsp_valid_in  = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `PALE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PALE_ASSERT_IMPL(a_full_only_at_capacity, clock, reset, accept && (status_c == ST_FULL), list_full)
   `PALE_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.shift_up, count_ff == $past(count_ff) + CNT_W'(1))
   `PALE_ASSERT_IMPL(a_rsp_from_drain, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DRAIN)

endmodule

/* rtl/core/positional_array_list_engine.sv */
// Top level of the positional array list engine: cell row, read-back fold and control.
//
// Usage: requests arrive on req_chan (mode, position, value) and each one gives exactly
// one response on rsp_chan (status, data, count). Both channels are valid/ready; a
// transaction moves at a rising clock edge with valid and ready high.
// The list lives in a row of cells, one entry per cell. Insert and delete shift every
// later entry by one place in the same cycle that the request is accepted.
// The read-back path gathers the addressed entry from the cell row into the cell read
// registers, then into group registers and then into the response register, which
// makes the response valid. No new request is taken before the previous one has moved
// through the fold and drain states of the control.
// The response register frees the request side: a new request is taken while the
// previous response still waits; its own response waits in the control until the
// receiver takes the earlier one, and no further request is taken meanwhile.
// Reset (synchronous, active high) empties the list and drops any pending response.
// Entry contents are not cleared; an entry is only ever read after it was written.
// Failed requests leave the list unchanged and report a status with zero data.
`timescale 1ns / 1ps

module positional_array_list_engine import pale_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   pale_req_if.sink          req_chan,
   pale_rsp_if.source        rsp_chan
);

   localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   cmd_type                 cmd;
   logic                    fold_en;
   logic signed [VAL_W-1:0] fold_data;
   logic signed [VAL_W-1:0] entry_q [CAPACITY];
   logic signed [VAL_W-1:0] rd_q    [CAPACITY];
   logic signed [VAL_W-1:0] group_ff [NGROUP];
   logic signed [VAL_W-1:0] group_in [NGROUP];

   pale_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req       (req_chan.payload),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp_chan.payload),
      .cmd       (cmd),
      .fold_en   (fold_en),
      .fold_data (fold_data)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = entry_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_right
         assign right_v = entry_q[i+1];
      end

      pale_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_v),
         .right_value (right_v),
         .entry       (entry_q[i]),
         .read_value  (rd_q[i])
      );
   end

   // At most one cell drives a nonzero read value, so OR acts as the select.
   for (genvar g = 0; g < NGROUP; g++) begin : g_group
      always_comb begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < CAPACITY) begin
               group_in[g] = group_in[g] | rd_q[g * GROUP_SIZE + j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (fold_en) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   always_comb begin
      fold_data = '0;
      for (int g = 0; g < NGROUP; g++) begin
         fold_data = fold_data | group_ff[g];
      end
   end

endmodule
